// ----- hdl/assert_macros.svh -----
// Assertion helper macros used by the interlock checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// Antecedent true implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent true implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/deil_pkg.sv -----
// ----------------------------------------------------------------------------
// Drive-enable interlock package
// Word types, configuration set, mode codes and register indexes.
// ----------------------------------------------------------------------------
package deil_pkg;

    // Mode codes
    localparam logic [2:0] MODE_IDLE        = 3'd0;
    localparam logic [2:0] MODE_SETUP_DRIVE = 3'd1;
    localparam logic [2:0] MODE_DRIVE       = 3'd2;
    localparam logic [2:0] MODE_SETUP_IDLE  = 3'd3;
    localparam logic [2:0] MODE_OVERCURRENT = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] CFG_OFF_THR     = 3'd0;
    localparam logic [2:0] CFG_REST_THR    = 3'd1;
    localparam logic [2:0] CFG_FAULT_TICKS = 3'd2;
    localparam logic [2:0] CFG_SOUND_TICKS = 3'd3;
    localparam logic [2:0] CFG_BLINK_TICKS = 3'd4;
    localparam logic [2:0] CFG_PEDAL_THR   = 3'd5;

    // Configuration reset values
    localparam logic [15:0] RST_OFF_THR     = 16'd0;
    localparam logic [15:0] RST_REST_THR    = 16'd500;
    localparam logic [15:0] RST_FAULT_TICKS = 16'd0;
    localparam logic [15:0] RST_SOUND_TICKS = 16'd150;
    localparam logic [15:0] RST_BLINK_TICKS = 16'd75;
    localparam logic [9:0]  RST_PEDAL_THR   = 10'd184;

    typedef struct packed {
        logic        throttle_implausible;
        logic        brake_pressed;
        logic        safety_loop_open;
        logic        button_event;
        logic        dropout_request;
        logic        over_current;
        logic [15:0] throttle_volts;
        logic [9:0]  pedal_raw;
    } tick_t;

    typedef struct packed {
        logic [2:0] mode_code;
        logic       throttle_select;
        logic       sound_on;
        logic       drive_led;
        logic       red_led;
        logic       blue_led;
        logic       plausibility_led;
        logic       throttle_plausible;
        logic       brake_flag;
        logic       brake_throttle_fault;
        logic       safety_loop_closed;
    } stat_t;

    typedef struct packed {
        logic [15:0] off_thr;
        logic [15:0] rest_thr;
        logic [15:0] fault_ticks;
        logic [15:0] sound_ticks;
        logic [15:0] blink_ticks;
        logic [9:0]  pedal_thr;
    } cfg_t;

endpackage

// ----- hdl/deil_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Interlock configuration registers
// Register file written over the configuration channel; always ready.
// ----------------------------------------------------------------------------
module deil_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [2:0]          wr_index,
    input  logic [15:0]         wr_data,
    output deil_pkg::cfg_t      cfg
);

    deil_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.off_thr     <= deil_pkg::RST_OFF_THR;
            cfg_reg.rest_thr    <= deil_pkg::RST_REST_THR;
            cfg_reg.fault_ticks <= deil_pkg::RST_FAULT_TICKS;
            cfg_reg.sound_ticks <= deil_pkg::RST_SOUND_TICKS;
            cfg_reg.blink_ticks <= deil_pkg::RST_BLINK_TICKS;
            cfg_reg.pedal_thr   <= deil_pkg::RST_PEDAL_THR;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                deil_pkg::CFG_OFF_THR:     cfg_reg.off_thr     <= wr_data;
                deil_pkg::CFG_REST_THR:    cfg_reg.rest_thr    <= wr_data;
                deil_pkg::CFG_FAULT_TICKS: cfg_reg.fault_ticks <= wr_data;
                deil_pkg::CFG_SOUND_TICKS: cfg_reg.sound_ticks <= wr_data;
                deil_pkg::CFG_BLINK_TICKS: cfg_reg.blink_ticks <= wr_data;
                deil_pkg::CFG_PEDAL_THR:   cfg_reg.pedal_thr   <= wr_data[9:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hdl/deil_fsm.sv -----
// ----------------------------------------------------------------------------
// Interlock mode engine
// Mode state, tick timer, event latches and held outputs; one step per word.
// ----------------------------------------------------------------------------
module deil_fsm #(
    parameter int TIMER_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  deil_pkg::tick_t     tick,
    input  deil_pkg::cfg_t      cfg,
    output deil_pkg::stat_t     stat
);

    localparam int CMP_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [2:0]            mode_reg,   mode_next;
    logic [TIMER_BITS-1:0] timer_reg,  timer_next;
    logic                  blink_reg,  blink_next;
    logic                  btn_reg,    btn_next;
    logic                  drop_reg,   drop_next;
    logic                  sel_reg,    sel_next;
    logic                  sound_reg,  sound_next;
    logic                  drive_reg,  drive_next;
    logic                  red_reg,    red_next;
    logic                  blue_reg,   blue_next;
    logic                  plaus_reg,  plaus_next;
    logic                  brake_reg,  brake_next;
    logic                  fault_reg,  fault_next;

    // A limit beyond the timer's range counts as reached at saturation.
    function automatic logic reached(input logic [TIMER_BITS-1:0] t,
                                     input logic [15:0] lim);
        return (CMP_W'(t) >= CMP_W'(lim)) || (t == TIMER_MAX);
    endfunction

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
        return (t == TIMER_MAX) ? t : t + TIMER_BITS'(1);
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        timer_next = timer_reg;
        blink_next = blink_reg;
        btn_next   = btn_reg | tick.button_event;
        drop_next  = drop_reg | tick.dropout_request;
        sel_next   = sel_reg;
        sound_next = sound_reg;
        drive_next = drive_reg;
        red_next   = red_reg;
        blue_next  = blue_reg;
        plaus_next = plaus_reg;
        brake_next = brake_reg;
        fault_next = fault_reg;

        unique case (mode_reg)
            deil_pkg::MODE_IDLE:
            begin
                plaus_next = ~tick.throttle_implausible;
                brake_next = tick.brake_pressed;
                blue_next  = tick.pedal_raw > cfg.pedal_thr;
                if (btn_next)
                begin
                    if (!drop_next)
                        mode_next = deil_pkg::MODE_SETUP_DRIVE;
                    btn_next  = 1'b0;
                    drop_next = 1'b0;
                end
            end
            deil_pkg::MODE_SETUP_DRIVE:
            begin
                plaus_next = ~tick.throttle_implausible;
                sel_next   = 1'b1;
                if (!reached(timer_reg, cfg.sound_ticks))
                begin
                    sound_next = 1'b1;
                    timer_next = sat_inc(timer_reg);
                end
                else
                begin
                    sound_next = 1'b0;
                    mode_next  = deil_pkg::MODE_DRIVE;
                end
            end
            deil_pkg::MODE_DRIVE:
            begin
                drive_next = 1'b1;
                brake_next = tick.brake_pressed;
                if (tick.brake_pressed && (tick.throttle_volts > cfg.off_thr))
                begin
                    if (reached(timer_reg, cfg.fault_ticks))
                    begin
                        fault_next = 1'b1;
                        mode_next  = deil_pkg::MODE_SETUP_IDLE;
                    end
                    else
                        timer_next = sat_inc(timer_reg);
                end
                else
                begin
                    timer_next = '0;
                    fault_next = 1'b0;
                end
                // implausibility check decides the plausible flag last
                plaus_next = ~tick.throttle_implausible;
                if (tick.throttle_implausible)
                    mode_next = deil_pkg::MODE_SETUP_IDLE;
                if (btn_next || drop_next)
                begin
                    mode_next = deil_pkg::MODE_SETUP_IDLE;
                    btn_next  = 1'b0;
                    drop_next = 1'b0;
                end
                if (tick.over_current)
                    mode_next = deil_pkg::MODE_OVERCURRENT;
            end
            deil_pkg::MODE_OVERCURRENT:
            begin
                plaus_next = 1'b1;
                red_next   = 1'b1;
                sel_next   = 1'b0;
                drive_next = blink_reg;
                timer_next = sat_inc(timer_reg);
                if (reached(timer_next, cfg.blink_ticks))
                begin
                    timer_next = '0;
                    if (!blink_reg)
                        blink_next = 1'b1;
                    else
                    begin
                        // end of a full blink cycle: exits are checked here
                        blink_next = 1'b0;
                        brake_next = tick.brake_pressed;
                        if (!tick.over_current && (tick.throttle_volts < cfg.rest_thr))
                        begin
                            btn_next   = 1'b0;
                            drive_next = 1'b1;
                            sel_next   = 1'b1;
                            mode_next  = deil_pkg::MODE_DRIVE;
                        end
                        if (btn_next || drop_next || tick.safety_loop_open)
                        begin
                            mode_next = deil_pkg::MODE_SETUP_IDLE;
                            btn_next  = 1'b0;
                            drop_next = 1'b0;
                        end
                        plaus_next = ~tick.throttle_implausible;
                        if (tick.throttle_implausible)
                            mode_next = deil_pkg::MODE_SETUP_IDLE;
                    end
                end
            end
            default:
            begin
                // setup idle, and the unused codes behave the same
                plaus_next = ~tick.throttle_implausible;
                drive_next = 1'b0;
                sel_next   = 1'b0;
                red_next   = 1'b0;
                blue_next  = 1'b0;
                mode_next  = deil_pkg::MODE_IDLE;
            end
        endcase

        if (mode_next != mode_reg)
        begin
            timer_next = '0;
            blink_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= deil_pkg::MODE_IDLE;
            timer_reg <= '0;
            blink_reg <= 1'b0;
            btn_reg   <= 1'b0;
            drop_reg  <= 1'b0;
            sel_reg   <= 1'b0;
            sound_reg <= 1'b0;
            drive_reg <= 1'b0;
            red_reg   <= 1'b0;
            blue_reg  <= 1'b0;
            plaus_reg <= 1'b1;
            brake_reg <= 1'b0;
            fault_reg <= 1'b0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            timer_reg <= timer_next;
            blink_reg <= blink_next;
            btn_reg   <= btn_next;
            drop_reg  <= drop_next;
            sel_reg   <= sel_next;
            sound_reg <= sound_next;
            drive_reg <= drive_next;
            red_reg   <= red_next;
            blue_reg  <= blue_next;
            plaus_reg <= plaus_next;
            brake_reg <= brake_next;
            fault_reg <= fault_next;
        end
    end

    always_comb
    begin
        stat.mode_code            = mode_reg;
        stat.throttle_select      = sel_next;
        stat.sound_on             = sound_next;
        stat.drive_led            = drive_next;
        stat.red_led              = red_next;
        stat.blue_led             = blue_next;
        stat.plausibility_led     = tick.throttle_implausible;
        stat.throttle_plausible   = plaus_next;
        stat.brake_flag           = brake_next;
        stat.brake_throttle_fault = fault_next;
        stat.safety_loop_closed   = ~tick.safety_loop_open;
    end

endmodule

// ----- hdl/drive_enable_safety_interlock.sv -----
// ----------------------------------------------------------------------------
// Drive-enable safety interlock
// Tick-driven mode machine gating throttle select, sound and indicator LEDs.
// ----------------------------------------------------------------------------
// Usage:
//   tick channel (tick_valid / tick_stall / tick_word): one word per timer
//   tick with the sampled pins. stat channel (stat_valid / stat_stall /
//   stat_word): one status word per tick, in order.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): register
//   writes, always ready; write only while no tick is in flight.
// Path: an accepted word waits in the input register; the mode step is one
//   pass of compare and counter logic into the result register (stat_word).
// Throughput: one tick per cycle while the result register is not stalled.
// Stall: the result register holds while stat_stall is high; tick_stall
//   rises only when the input register is full and a held result is stalled.
// Reset: rst_n clears the mode to idle, timer and latches to zero, held
//   outputs to zero with the plausible flag set, and the registers to their
//   defaults. No words are pending after reset.
// ----------------------------------------------------------------------------
module drive_enable_safety_interlock #(
    parameter int TIMER_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                tick_valid,
    output logic                tick_stall,
    input  deil_pkg::tick_t     tick_word,
    output logic                stat_valid,
    input  logic                stat_stall,
    output deil_pkg::stat_t     stat_word,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    deil_pkg::cfg_t  cfg;
    deil_pkg::tick_t in_word_reg;
    logic            in_valid_reg;
    deil_pkg::stat_t stat_comb;
    deil_pkg::stat_t out_word_reg;
    logic            out_valid_reg;
    logic            advance;
    logic            step;

    assign cfg_ready = 1'b1;

    deil_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // result register can take a word when empty or being drained
    assign advance    = ~out_valid_reg | ~stat_stall;
    assign step       = in_valid_reg & advance;
    assign tick_stall = in_valid_reg & ~advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick_valid && !tick_stall)
            in_valid_reg <= 1'b1;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (tick_valid && !tick_stall)
            in_word_reg <= tick_word;
    end

    deil_fsm #(
        .TIMER_BITS (TIMER_BITS)
    ) u_fsm (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .tick  (in_word_reg),
        .cfg   (cfg),
        .stat  (stat_comb)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (!stat_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_word_reg <= stat_comb;
    end

    assign stat_valid = out_valid_reg;
    assign stat_word  = out_word_reg;

endmodule

// ----- hdl/deil_checker.sv -----
// ----------------------------------------------------------------------------
// Interlock port checker
// Port-level checks on the status channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deil_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                stat_valid,
    input  logic                stat_stall,
    input  deil_pkg::stat_t     stat_word
);

    // a held status word stays put
    `ASSERT_NEXT(a_stat_hold, clk, rst_n, stat_valid && stat_stall, stat_valid && $stable(stat_word))

    // sound only sounds during setup drive
    `ASSERT_IMPLIES(a_sound_setup, clk, rst_n, stat_valid && stat_word.sound_on, stat_word.mode_code == deil_pkg::MODE_SETUP_DRIVE)

    // setup drive always enables the throttle
    `ASSERT_IMPLIES(a_setup_sel, clk, rst_n, stat_valid && stat_word.mode_code == deil_pkg::MODE_SETUP_DRIVE, stat_word.throttle_select)

    // over-current always shows the warning LED
    `ASSERT_IMPLIES(a_oc_red, clk, rst_n, stat_valid && stat_word.mode_code == deil_pkg::MODE_OVERCURRENT, stat_word.red_led)

endmodule

bind drive_enable_safety_interlock deil_checker u_deil_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat_valid (stat_valid),
    .stat_stall (stat_stall),
    .stat_word  (stat_word)
);
